### hdl/mccpm_pkg.sv
// Shared types and constants of the MIDI controller parameter mapper.
`timescale 1ns / 1ps
package mccpm_pkg;

	// Command codes carried on the slave tuser
	typedef enum logic [3:0] {
		CMD_DEFINE   = 4'd0,
		CMD_UNDEFINE = 4'd1,
		CMD_SET      = 4'd2,
		CMD_GET      = 4'd3,
		CMD_RESET    = 4'd4,
		CMD_RESETALL = 4'd5,
		CMD_BIND     = 4'd6,
		CMD_UNBIND   = 4'd7,
		CMD_MESSAGE  = 4'd8,
		CMD_COUNT    = 4'd9
	} cmd_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_UNDEF  = 3'd1,
		ST_FULL   = 3'd2,
		ST_BADARG = 3'd3,
		ST_NOBIND = 3'd4
	} status_t;

	// Parameter kinds
	localparam logic [1:0] KIND_REAL = 2'd0;
	localparam logic [1:0] KIND_INT  = 2'd1;
	localparam logic [1:0] KIND_BOOL = 2'd2;
	localparam logic [1:0] KIND_BAD  = 2'd3;

	localparam int CH_COUNT  = 16;
	localparam int CC_BITS   = 7;
	localparam int MAP_AW    = 11;
	localparam int MAP_DEPTH = 2048;

	localparam logic [7:0]  CC_DIV    = 8'd127;
	localparam logic [32:0] HALF_Q    = 33'h0_0000_8000;
	localparam logic [31:0] ONE_Q     = 32'h0001_0000;
	localparam logic [32:0] ROUND_MAX = 33'h0_7FFF_0000;

endpackage

### hdl/mccpm_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module mccpm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word; the read word is registered and appears in the next cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hdl/midi_cc_parameter_mapper_core.sv
// Top level of the MIDI controller parameter mapper.
`timescale 1ns / 1ps
// Usage: one command word enters on the slave stream (command code on
// s_tuser, arguments on s_tdata) and one result word leaves on the master
// stream (status, slot, value, defined count). Commands are handled one at
// a time by a small sequencer around shared slot RAMs, a controller map RAM
// and one arithmetic path; s_tready is high only while the sequencer idles.
// Result valid and s_tready return in the same cycle. Define runs a linear
// free-slot scan; reset all reads and writes each slot; a set of an integer
// value in range takes an extra rounding step; a controller message divides
// by 127, which folds 128a + b into 127a + (a + b) once a cycle until the
// remainder is below 128.
// Reset: the control state clears at once, then a clearing pass writes
// every one of the 2048 controller map entries, one a cycle, before the
// first command is taken (s_tready stays low meanwhile).
// Stall: a finished result sits in the output register; the next command
// is accepted meanwhile, and the sequencer only waits at its own end if the
// previous result was not yet taken.
module midi_cc_parameter_mapper_core #(
	parameter int SLOT_COUNT = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// slot[5:0], kind[7:6], low_value[39:8], high_value[71:40],
	// new_value[103:72], channel[108:104], controller[115:109],
	// cc_value[122:116], zero[127:123]
	input  logic [127:0] s_tdata,
	// command[3:0]
	input  logic [3:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0], result_slot[8:3], result_value[40:9], defined_count[47:41]
	output logic [47:0]  m_tdata
);
	import mccpm_pkg::*;

	localparam int SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SXW = SW + 6;
	localparam int CW  = $clog2(SLOT_COUNT + 1);
	localparam int PW  = 2 + 3 * 32;

	typedef enum logic [14:0] {
		S_CLEAR = 15'b000000000000001,
		S_IDLE  = 15'b000000000000010,
		S_DEC   = 15'b000000000000100,
		S_FIND  = 15'b000000000001000,
		S_MAPW  = 15'b000000000010000,
		S_WAIT  = 15'b000000000100000,
		S_ACT   = 15'b000000001000000,
		S_BIND  = 15'b000000010000000,
		S_DIV   = 15'b000000100000000,
		S_ADD   = 15'b000001000000000,
		S_CLAMP = 15'b000010000000000,
		S_RND   = 15'b000100000000000,
		S_RAW   = 15'b001000000000000,
		S_RAX   = 15'b010000000000000,
		S_DONE  = 15'b100000000000000
	} state_t;

	state_t state_q;

	// Captured command
	logic [3:0]         cmd_q;
	logic [5:0]         in_slot_q;
	logic [1:0]         kind_q;
	logic [31:0]        lo_q, hi_q, nv_q;
	logic [4:0]         ch_q;
	logic [6:0]         cc_q;
	logic [6:0]         ccv_q;

	// Control and working registers
	logic [SW-1:0]         cur_q;
	logic [CW-1:0]         live_q;
	logic [SLOT_COUNT-1:0] defined_q;
	logic [SLOT_COUNT-1:0] bound_q;
	status_t               res_status_q;
	logic [5:0]            res_slot_q;
	logic [31:0]           res_val_q;
	logic [39:0]           mag_q;
	logic                  neg_q;
	logic [31:0]           quo_q;
	logic signed [41:0]    v_q;
	logic [32:0]           t_q;
	logic [MAP_AW:0]       clr_q;
	logic                  m_tvalid_q;
	logic [47:0]           m_data_q;

	// RAM ports
	logic [PW-1:0]     prm_rd;
	logic [31:0]       cur_rd;
	logic [11:0]       bnd_rd;
	logic [SW:0]       map_rd;
	logic              prm_we, cur_we, bnd_we, map_we;
	logic [31:0]       cur_wd;
	logic [MAP_AW-1:0] map_wa, map_ra;
	logic [SW:0]       map_wd;

	// Decoded fields
	cmd_t          cmd;
	logic [SXW-1:0] slot_x, cur_x, mslot_x;
	logic [SW-1:0] slot_idx, mslot;
	logic          slot_ok, live, ch_ok, map_hit;
	logic [4:0]    ch_m1, bch_m1;
	logic [MAP_AW-1:0] drop_wa;
	logic [5:0]    cur6;
	logic [1:0]    prm_kind;
	logic [31:0]   prm_max, prm_min, prm_def;
	logic signed [41:0] minx, maxx, addq;
	logic signed [32:0] diff;
	logic signed [40:0] prod;
	logic [39:0]   prod_mag;
	logic          v_lt, v_gt, clamp_final;
	logic [31:0]   clamp_val, rnd_val;
	logic [32:0]   tm, trunc, rnd_full;

	assign cmd      = cmd_t'(cmd_q);
	assign slot_x   = SXW'(in_slot_q);
	assign slot_idx = slot_x[SW-1:0];
	assign slot_ok  = slot_x < SXW'(SLOT_COUNT);
	assign live     = slot_ok && defined_q[slot_idx];
	assign ch_ok    = (ch_q != 5'd0) && (ch_q <= 5'(CH_COUNT));
	assign ch_m1    = ch_q - 5'd1;
	assign map_ra   = {ch_m1[3:0], cc_q};
	assign cur_x    = SXW'(cur_q);
	assign cur6     = cur_x[5:0];

	assign mslot    = map_rd[SW-1:0];
	assign mslot_x  = SXW'(mslot);
	assign map_hit  = map_rd[SW] && (mslot_x < SXW'(SLOT_COUNT)) && defined_q[mslot];

	assign bch_m1   = bnd_rd[11:7] - 5'd1;
	assign drop_wa  = {bch_m1[3:0], bnd_rd[6:0]};

	assign prm_kind = prm_rd[97:96];
	assign prm_max  = prm_rd[95:64];
	assign prm_min  = prm_rd[63:32];
	assign prm_def  = prm_rd[31:0];
	assign minx     = 42'(signed'(prm_min));
	assign maxx     = 42'(signed'(prm_max));

	// Scale product and signed quotient
	assign diff     = 33'(signed'(prm_max)) - 33'(signed'(prm_min));
	assign prod     = 41'(signed'({1'b0, ccv_q})) * 41'(diff);
	assign prod_mag = prod[40] ? 40'(-prod) : prod[39:0];
	assign addq     = neg_q ? -42'(signed'({10'd0, quo_q})) : 42'(signed'({10'd0, quo_q}));

	// Range clamp, then kind handling
	assign v_lt        = v_q < minx;
	assign v_gt        = v_q > maxx;
	assign clamp_final = v_lt || v_gt || (prm_kind != KIND_INT);
	always_comb begin
		priority if (v_lt) begin
			clamp_val = prm_min;
		end else if (v_gt) begin
			clamp_val = prm_max;
		end else if (prm_kind == KIND_BOOL) begin
			clamp_val = (v_q >= 42'sd32768) ? ONE_Q : 32'd0;
		end else begin
			clamp_val = v_q[31:0];
		end
	end

	// Add one half, truncate the magnitude toward zero, then saturate positive results
	assign tm       = t_q[32] ? -t_q : t_q;
	assign trunc    = {tm[32:16], 16'h0000};
	assign rnd_full = t_q[32] ? -trunc : trunc;
	assign rnd_val  = (!t_q[32] && (trunc > ROUND_MAX)) ? ROUND_MAX[31:0] : rnd_full[31:0];

	// Write strobes of the RAMs
	always_comb begin
		prm_we = 1'b0;
		cur_we = 1'b0;
		cur_wd = nv_q;
		bnd_we = 1'b0;
		map_we = 1'b0;
		map_wa = drop_wa;
		map_wd = '0;
		unique case (state_q)
			S_CLEAR: begin
				map_we = 1'b1;
				map_wa = clr_q[MAP_AW-1:0];
			end
			S_FIND: begin
				prm_we = !defined_q[cur_q];
				cur_we = !defined_q[cur_q];
			end
			S_ACT: begin
				unique case (cmd)
					CMD_UNDEFINE, CMD_UNBIND, CMD_BIND: begin
						map_we = bound_q[cur_q];
						bnd_we = (cmd == CMD_BIND);
					end
					CMD_RESET: begin
						cur_we = 1'b1;
						cur_wd = prm_def;
					end
					default: begin
					end
				endcase
			end
			S_BIND: begin
				map_we = 1'b1;
				map_wa = map_ra;
				map_wd = {1'b1, cur_q};
			end
			S_CLAMP: begin
				cur_we = clamp_final;
				cur_wd = clamp_val;
			end
			S_RND: begin
				cur_we = 1'b1;
				cur_wd = rnd_val;
			end
			S_RAX: begin
				cur_we = defined_q[cur_q];
				cur_wd = prm_def;
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			live_q       <= '0;
			defined_q    <= '0;
			bound_q      <= '0;
			m_tvalid_q   <= 1'b0;
			cur_q        <= '0;
			res_status_q <= ST_OK;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (MAP_AW+1)'(MAP_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					res_status_q <= ST_OK;
					res_slot_q   <= '0;
					res_val_q    <= '0;
					cur_q        <= slot_idx;
					state_q      <= S_DONE;
					unique case (cmd)
						CMD_DEFINE: begin
							cur_q <= '0;
							if (kind_q == KIND_BAD) begin
								res_status_q <= ST_BADARG;
							end else begin
								state_q <= S_FIND;
							end
						end
						CMD_UNDEFINE, CMD_SET, CMD_GET, CMD_RESET, CMD_UNBIND: begin
							if (!live) begin
								res_status_q <= ST_UNDEF;
							end else begin
								state_q <= S_WAIT;
							end
						end
						CMD_RESETALL: begin
							cur_q   <= '0;
							state_q <= S_RAW;
						end
						CMD_BIND: begin
							priority if (!ch_ok) begin
								res_status_q <= ST_BADARG;
							end else if (!live) begin
								res_status_q <= ST_UNDEF;
							end else begin
								state_q <= S_WAIT;
							end
						end
						CMD_MESSAGE: begin
							if (!ch_ok) begin
								res_status_q <= ST_BADARG;
							end else begin
								state_q <= S_MAPW;
							end
						end
						CMD_COUNT: begin
						end
						default: begin
							res_status_q <= ST_BADARG;
						end
					endcase
				end
				S_FIND: begin
					// Scan for the first free slot
					priority if (!defined_q[cur_q]) begin
						defined_q[cur_q] <= 1'b1;
						bound_q[cur_q]   <= 1'b0;
						live_q           <= live_q + 1'b1;
						res_slot_q       <= cur6;
						res_val_q        <= nv_q;
						state_q          <= S_DONE;
					end else if (cur_q == SW'(SLOT_COUNT - 1)) begin
						res_status_q <= ST_FULL;
						state_q      <= S_DONE;
					end else begin
						cur_q <= cur_q + 1'b1;
					end
				end
				S_MAPW: begin
					if (map_hit) begin
						cur_q   <= mslot;
						state_q <= S_WAIT;
					end else begin
						res_status_q <= ST_NOBIND;
						state_q      <= S_DONE;
					end
				end
				S_WAIT: begin
					state_q <= S_ACT;
				end
				S_ACT: begin
					res_slot_q <= cur6;
					state_q    <= S_DONE;
					unique case (cmd)
						CMD_UNDEFINE: begin
							bound_q[cur_q]   <= 1'b0;
							defined_q[cur_q] <= 1'b0;
							live_q           <= live_q - 1'b1;
						end
						CMD_UNBIND: begin
							bound_q[cur_q] <= 1'b0;
						end
						CMD_BIND: begin
							bound_q[cur_q] <= 1'b1;
							state_q        <= S_BIND;
						end
						CMD_SET: begin
							v_q     <= 42'(signed'(nv_q));
							state_q <= S_CLAMP;
						end
						CMD_GET: begin
							res_val_q <= cur_rd;
						end
						CMD_RESET: begin
							res_val_q <= prm_def;
						end
						CMD_MESSAGE: begin
							neg_q   <= prod[40];
							mag_q   <= prod_mag;
							quo_q   <= '0;
							state_q <= S_DIV;
						end
						default: begin
						end
					endcase
				end
				S_BIND: begin
					state_q <= S_DONE;
				end
				S_DIV: begin
					// Fold 128a + b into 127a + (a + b) until below 128
					if (mag_q[39:7] == 33'd0) begin
						if (mag_q[6:0] == CC_DIV[6:0]) begin
							quo_q <= quo_q + 32'd1;
						end
						state_q <= S_ADD;
					end else begin
						quo_q <= quo_q + mag_q[38:7];
						mag_q <= {7'd0, mag_q[39:7]} + {33'd0, mag_q[6:0]};
					end
				end
				S_ADD: begin
					v_q     <= minx + addq;
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					t_q <= v_q[32:0] + HALF_Q;
					if (clamp_final) begin
						res_val_q <= clamp_val;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_RND;
					end
				end
				S_RND: begin
					res_val_q <= rnd_val;
					state_q   <= S_DONE;
				end
				S_RAW: begin
					state_q <= S_RAX;
				end
				S_RAX: begin
					if (cur_q == SW'(SLOT_COUNT - 1)) begin
						state_q <= S_DONE;
					end else begin
						cur_q   <= cur_q + 1'b1;
						state_q <= S_RAW;
					end
				end
				S_DONE: begin
					// Hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the command word and the result word
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			cmd_q     <= s_tuser;
			in_slot_q <= s_tdata[5:0];
			kind_q    <= s_tdata[7:6];
			lo_q      <= s_tdata[39:8];
			hi_q      <= s_tdata[71:40];
			nv_q      <= s_tdata[103:72];
			ch_q      <= s_tdata[108:104];
			cc_q      <= s_tdata[115:109];
			ccv_q     <= s_tdata[122:116];
		end
		if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_data_q <= {7'(live_q), res_val_q, res_slot_q, res_status_q};
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

	// Slot parameters: kind, maximum, minimum, default
	mccpm_ram #(.WIDTH(PW), .DEPTH(SLOT_COUNT)) u_prm_ram (
		.clk   (clk),
		.we    (prm_we),
		.waddr (cur_q),
		.wdata ({kind_q, hi_q, lo_q, nv_q}),
		.raddr (cur_q),
		.rdata (prm_rd)
	);

	// Slot current values
	mccpm_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_q),
		.wdata (cur_wd),
		.raddr (cur_q),
		.rdata (cur_rd)
	);

	// Slot binding records: channel, controller
	mccpm_ram #(.WIDTH(12), .DEPTH(SLOT_COUNT)) u_bnd_ram (
		.clk   (clk),
		.we    (bnd_we),
		.waddr (cur_q),
		.wdata ({ch_q, cc_q}),
		.raddr (cur_q),
		.rdata (bnd_rd)
	);

	// Channel and controller to slot map: valid, slot
	mccpm_ram #(.WIDTH(SW + 1), .DEPTH(MAP_DEPTH)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_wa),
		.wdata (map_wd),
		.raddr (map_ra),
		.rdata (map_rd)
	);
endmodule
